@@ rtl/ubxfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Shared types, constants and field tables of the frame receiver.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

   localparam int MAX_FRAME       = 256;
   localparam int PVT_BYTES       = 92;
   localparam int PVT_AW          = $clog2(PVT_BYTES);
   localparam int NUM_FIELDS      = 28;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
   localparam int FIX_BYTE        = 20;

   localparam logic [4:0] FIELD_LAST = 5'(NUM_FIELDS - 1);

   // configuration register indexes
   localparam logic [2:0] REG_SYNC_FIRST   = 3'd0;
   localparam logic [2:0] REG_SYNC_SECOND  = 3'd1;
   localparam logic [2:0] REG_NAV_CLASS    = 3'd2;
   localparam logic [2:0] REG_PVT_ID       = 3'd3;
   localparam logic [2:0] REG_ACK_CLASS    = 3'd4;
   localparam logic [2:0] REG_MIN_FIX_TYPE = 3'd5;

   typedef enum logic [2:0] {
      ST_PVT      = 3'd0,
      ST_ACK      = 3'd1,
      ST_OTHER    = 3'd2,
      ST_BAD_CK   = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_SHORT    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FIX_NONE  = 2'd0,
      FIX_NOFIX = 2'd1,
      FIX_ACQ   = 2'd2
   } fix_type;

   typedef enum logic [2:0] {
      PH_SYNC1   = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_HEAD    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CKA     = 3'd4,
      PH_CKB     = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      B_IDLE = 2'd0,
      B_ADDR = 2'd1,
      B_ACC  = 2'd2,
      B_EMIT = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] nav_class;
      logic [7:0] pvt_id;
      logic [7:0] ack_class;
      logic [7:0] min_fix_type;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic       fix_ok;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [PVT_AW-1:0] addr;
      logic [7:0]        data;
   } buf_wr_type;

   function automatic logic [PVT_AW-1:0] fld_off(input logic [4:0] f);
      logic [PVT_AW-1:0] o;
      case (f)
         5'd0:    o = PVT_AW'(0);
         5'd1:    o = PVT_AW'(4);
         5'd2:    o = PVT_AW'(6);
         5'd3:    o = PVT_AW'(7);
         5'd4:    o = PVT_AW'(8);
         5'd5:    o = PVT_AW'(9);
         5'd6:    o = PVT_AW'(10);
         5'd7:    o = PVT_AW'(11);
         5'd8:    o = PVT_AW'(12);
         5'd9:    o = PVT_AW'(16);
         5'd10:   o = PVT_AW'(20);
         5'd11:   o = PVT_AW'(21);
         5'd12:   o = PVT_AW'(23);
         5'd13:   o = PVT_AW'(24);
         5'd14:   o = PVT_AW'(28);
         5'd15:   o = PVT_AW'(32);
         5'd16:   o = PVT_AW'(36);
         5'd17:   o = PVT_AW'(40);
         5'd18:   o = PVT_AW'(44);
         5'd19:   o = PVT_AW'(48);
         5'd20:   o = PVT_AW'(52);
         5'd21:   o = PVT_AW'(56);
         5'd22:   o = PVT_AW'(60);
         5'd23:   o = PVT_AW'(64);
         5'd24:   o = PVT_AW'(68);
         5'd25:   o = PVT_AW'(72);
         5'd26:   o = PVT_AW'(76);
         5'd27:   o = PVT_AW'(84);
         default: o = PVT_AW'(0);
      endcase
      return o;
   endfunction

   // field length in bytes minus one
   function automatic logic [1:0] fld_lenm1(input logic [4:0] f);
      logic [1:0] l;
      case (f)
         5'd1, 5'd26:                                    l = 2'd1;
         5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd10,
         5'd11, 5'd12:                                   l = 2'd0;
         default:                                        l = 2'd3;
      endcase
      return l;
   endfunction

   function automatic logic fld_sgn(input logic [4:0] f);
      logic s;
      case (f)
         5'd9, 5'd13, 5'd14, 5'd15, 5'd16, 5'd19, 5'd20,
         5'd21, 5'd22, 5'd23, 5'd27:                     s = 1'b1;
         default:                                        s = 1'b0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ubxfr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ubxfr_front
// Sync hunt, header parse, checksum and payload capture; queues one job
// per finished frame.
// ----------------------------------------------------------------------------
module ubxfr_front
   import ubxfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  byte_data,
   output logic             byte_ready,
   input  wire cfg_type     cfg,
   input  wire logic        pvt_busy,
   input  wire logic        queue_full,
   output logic             push,
   output job_type          push_job,
   output buf_wr_type       buf_wr
);

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  ck_a_ff, ck_a_in;
   logic [7:0]  fix_byte_ff, fix_byte_in;

   logic        take;
   logic [7:0]  add_a;
   logic [15:0] count_inc;
   logic [16:0] frame_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         count_ff    <= '0;
         len_ff      <= '0;
         class_ff    <= '0;
         id_ff       <= '0;
         sum_a_ff    <= '0;
         sum_b_ff    <= '0;
         ck_a_ff     <= '0;
         fix_byte_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         len_ff      <= len_in;
         class_ff    <= class_in;
         id_ff       <= id_in;
         sum_a_ff    <= sum_a_in;
         sum_b_ff    <= sum_b_in;
         ck_a_ff     <= ck_a_in;
         fix_byte_ff <= fix_byte_in;
      end
   end

   // payload may not overwrite the buffer while a field burst still reads it
   assign byte_ready = !queue_full && !(phase_ff == PH_PAYLOAD && pvt_busy);
   assign take       = byte_valid && byte_ready;
   assign add_a      = sum_a_ff + byte_data;
   assign count_inc  = count_ff + 16'd1;
   assign frame_len  = {1'b0, byte_data, len_ff[7:0]} + 17'd8;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      class_in    = class_ff;
      id_in       = id_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      ck_a_in     = ck_a_ff;
      fix_byte_in = fix_byte_ff;
      push        = 1'b0;
      // fix type is judged against the threshold in force at frame end
      push_job    = '{status: ST_OTHER, msg_class: class_ff, msg_id: id_ff,
                      fix_ok: fix_byte_ff >= cfg.min_fix_type};
      buf_wr      = '{en: 1'b0, addr: count_ff[PVT_AW-1:0], data: byte_data};
      if (take) begin
         case (phase_ff)
            PH_SYNC1: begin
               if (byte_data == cfg.sync_first) phase_in = PH_SYNC2;
            end
            PH_SYNC2: begin
               if (byte_data == cfg.sync_second) begin
                  phase_in = PH_HEAD;
                  count_in = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
               end else if (byte_data != cfg.sync_first) begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_HEAD: begin
               sum_a_in = add_a;
               sum_b_in = sum_b_ff + add_a;
               count_in = count_inc;
               case (count_ff[1:0])
                  2'd0:    class_in = byte_data;
                  2'd1:    id_in = byte_data;
                  2'd2:    len_in = {8'd0, byte_data};
                  default: begin
                     len_in   = {byte_data, len_ff[7:0]};
                     count_in = '0;
                     if (frame_len > 17'(MAX_FRAME)) begin
                        phase_in        = PH_SYNC1;
                        push            = 1'b1;
                        push_job.status = ST_OVERFLOW;
                     end else if ({byte_data, len_ff[7:0]} != 16'd0) begin
                        phase_in = PH_PAYLOAD;
                     end else begin
                        phase_in = PH_CKA;
                     end
                  end
               endcase
            end
            PH_PAYLOAD: begin
               sum_a_in  = add_a;
               sum_b_in  = sum_b_ff + add_a;
               buf_wr.en = count_ff < 16'(PVT_BYTES);
               if (count_ff == 16'(FIX_BYTE)) fix_byte_in = byte_data;
               count_in  = count_inc;
               if (count_inc >= len_ff) phase_in = PH_CKA;
            end
            PH_CKA: begin
               ck_a_in  = byte_data;
               phase_in = PH_CKB;
            end
            PH_CKB: begin
               phase_in = PH_SYNC1;
               push     = 1'b1;
               if (sum_a_ff != ck_a_ff || sum_b_ff != byte_data) begin
                  push_job.status = ST_BAD_CK;
               end else if (class_ff == cfg.nav_class && id_ff == cfg.pvt_id) begin
                  push_job.status = (len_ff < 16'(PVT_BYTES)) ? ST_SHORT : ST_PVT;
               end else if (class_ff == cfg.ack_class) begin
                  push_job.status = ST_ACK;
               end
            end
            default: phase_in = PH_SYNC1;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) buf_wr.en |-> !pvt_busy)
      else $error("payload write while field burst pending");
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("job pushed into full queue");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_CKB && $past(phase_ff) != PH_CKB)
                    |-> $past(phase_ff) == PH_CKA)
      else $error("check byte b not preceded by check byte a");

endmodule
`default_nettype wire

@@ rtl/ubxfr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ubxfr_queue
// Small job queue between frame parser and result generator.
// ----------------------------------------------------------------------------
module ubxfr_queue
   import ubxfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full    = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> !empty)
      else $error("queue empty after push");

endmodule
`default_nettype wire

@@ rtl/ubxfr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ubxfr_back
// Payload buffer and result generator: one status result per job, or the
// 28 pvt fields read byte by byte from the buffer.
// ----------------------------------------------------------------------------
module ubxfr_back
   import ubxfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire buf_wr_type  buf_wr,
   input  wire logic        job_valid,
   input  wire job_type     job,
   output logic             pop,
   output logic             pvt_done,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output status_type       rsp_status,
   output logic [7:0]       rsp_msg_class,
   output logic [7:0]       rsp_msg_id,
   output logic [4:0]       rsp_field_index,
   output logic [32:0]      rsp_field_value,
   output fix_type          rsp_fix_state,
   output logic             rsp_last
);

   logic [7:0]        buf_mem [PVT_BYTES];
   logic [7:0]        rd_ff;
   logic [PVT_AW-1:0] rd_addr;

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   fix_type           fix_ff, fix_in;
   logic [4:0]        fld_ff, fld_in;
   logic [1:0]        byte_ff, byte_in;
   logic [31:0]       acc_ff, acc_in;

   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [7:0]        out_class_ff, out_class_in;
   logic [7:0]        out_id_ff, out_id_in;
   logic [4:0]        out_index_ff, out_index_in;
   logic [32:0]       out_value_ff, out_value_in;
   fix_type           out_fix_ff, out_fix_in;
   logic              out_last_ff, out_last_in;

   logic              is_pvt;
   logic              slot_free;
   logic              fld_last;
   logic [32:0]       fld_value;

   assign rd_addr = fld_off(fld_ff) + PVT_AW'(byte_ff);

   always_ff @(posedge clock) begin
      if (buf_wr.en) buf_mem[buf_wr.addr] <= buf_wr.data;
      rd_ff <= buf_mem[rd_addr];
   end

   assign is_pvt    = job_ff.status == ST_PVT;
   assign slot_free = !out_valid_ff || rsp_tready;
   assign fld_last  = !is_pvt || fld_ff == FIELD_LAST;
   assign fld_value = (fld_sgn(fld_ff) && acc_ff[31]) ? {1'b1, acc_ff} : {1'b0, acc_ff};

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      fix_in        = fix_ff;
      fld_in        = fld_ff;
      byte_in       = byte_ff;
      acc_in        = acc_ff;
      pop           = 1'b0;
      pvt_done      = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_class_in  = out_class_ff;
      out_id_in     = out_id_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_fix_in    = out_fix_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               pop     = 1'b1;
               job_in  = job;
               fld_in  = '0;
               byte_in = '0;
               acc_in  = '0;
               if (job.status == ST_PVT) begin
                  fix_in   = job.fix_ok ? FIX_ACQ : FIX_NOFIX;
                  state_in = B_ADDR;
               end else begin
                  state_in = B_EMIT;
               end
            end
         end
         B_ADDR: state_in = B_ACC;
         B_ACC: begin
            acc_in = acc_ff | ({24'd0, rd_ff} << {byte_ff, 3'b000});
            if (byte_ff == fld_lenm1(fld_ff)) begin
               state_in = B_EMIT;
            end else begin
               byte_in  = byte_ff + 2'd1;
               state_in = B_ADDR;
            end
         end
         B_EMIT: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_status_in = job_ff.status;
               out_class_in  = job_ff.msg_class;
               out_id_in     = job_ff.msg_id;
               out_index_in  = is_pvt ? fld_ff : 5'd0;
               out_value_in  = is_pvt ? fld_value : 33'd0;
               out_fix_in    = fix_ff;
               out_last_in   = fld_last;
               if (fld_last) begin
                  pvt_done = is_pvt;
                  state_in = B_IDLE;
               end else begin
                  fld_in   = fld_ff + 5'd1;
                  byte_in  = '0;
                  acc_in   = '0;
                  state_in = B_ADDR;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         fix_ff       <= FIX_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fix_ff       <= fix_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff        <= job_in;
      fld_ff        <= fld_in;
      byte_ff       <= byte_in;
      acc_ff        <= acc_in;
      out_status_ff <= out_status_in;
      out_class_ff  <= out_class_in;
      out_id_ff     <= out_id_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_fix_ff    <= out_fix_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_msg_class   = out_class_ff;
   assign rsp_msg_id      = out_id_ff;
   assign rsp_field_index = out_index_ff;
   assign rsp_field_value = out_value_ff;
   assign rsp_fix_state   = out_fix_ff;
   assign rsp_last        = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == B_ACC) |-> $past(state_ff) == B_ADDR)
      else $error("accumulate without preceding buffer read");
   assert property (@(posedge clock) disable iff (reset)
                    (out_valid_ff && out_status_ff == ST_PVT) |-> out_fix_ff != FIX_NONE)
      else $error("pvt field without fix update");
   assert property (@(posedge clock) disable iff (reset)
                    pvt_done |-> fld_ff == FIELD_LAST)
      else $error("field burst ended early");

endmodule
`default_nettype wire

@@ rtl/ubx_frame_receiver_pvt_extract.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ubx_frame_receiver_pvt_extract
// Binary navigation frame receiver with checksum check and PVT field output.
// ----------------------------------------------------------------------------
// Received bytes enter on req_* and are taken one per clock; the parser never
// holds a byte except when its 4-entry job queue is full, or while it is in
// the payload of a frame and a PVT job of an earlier frame is queued or still
// reads the 92-byte payload buffer. Each finished frame gives one result,
// except a checked full PVT frame which gives 28, marked by rsp_tlast on the
// final one. The field burst reads the payload buffer byte by byte through
// an address state and an accumulate state, then emits each field, waiting
// while the previous result is not yet taken. Status codes ride on rsp_tuser.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_pvt_extract
   import ubxfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] msg_class, [15:8] msg_id, [20:16] field_index,
   // [53:21] field_value, [55:54] fix_state
   output logic [55:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,    // [2:0] status
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] pvt_cnt_ff, pvt_cnt_in;

   logic       push, pop, queue_full, queue_empty, pvt_done;
   job_type    push_job, pop_job;
   buf_wr_type buf_wr;

   status_type rsp_status;
   logic [7:0] rsp_msg_class, rsp_msg_id;
   logic [4:0] rsp_field_index;
   logic [32:0] rsp_field_value;
   fix_type    rsp_fix_state;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_SYNC_FIRST:   cfg_in.sync_first   = csr_wdata;
            REG_SYNC_SECOND:  cfg_in.sync_second  = csr_wdata;
            REG_NAV_CLASS:    cfg_in.nav_class    = csr_wdata;
            REG_PVT_ID:       cfg_in.pvt_id       = csr_wdata;
            REG_ACK_CLASS:    cfg_in.ack_class    = csr_wdata;
            REG_MIN_FIX_TYPE: cfg_in.min_fix_type = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // pvt jobs queued or in progress, each one still owns the payload buffer
   always_comb begin
      pvt_cnt_in = pvt_cnt_ff + 3'(push && push_job.status == ST_PVT) - 3'(pvt_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '{sync_first: 8'd181, sync_second: 8'd98, nav_class: 8'd1,
                         pvt_id: 8'd7, ack_class: 8'd5, min_fix_type: 8'd2};
         pvt_cnt_ff <= '0;
      end else begin
         cfg_ff     <= cfg_in;
         pvt_cnt_ff <= pvt_cnt_in;
      end
   end

   ubxfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_ready (req_tready),
      .cfg        (cfg_ff),
      .pvt_busy   (pvt_cnt_ff != 3'd0),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job),
      .buf_wr     (buf_wr)
   );

   ubxfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   ubxfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .buf_wr          (buf_wr),
      .job_valid       (!queue_empty),
      .job             (pop_job),
      .pop             (pop),
      .pvt_done        (pvt_done),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_msg_class   (rsp_msg_class),
      .rsp_msg_id      (rsp_msg_id),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_fix_state   (rsp_fix_state),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {rsp_fix_state, rsp_field_value, rsp_field_index,
                       rsp_msg_id, rsp_msg_class};

   assert property (@(posedge clock) disable iff (reset)
                    pvt_cnt_ff <= 3'(QUEUE_DEPTH + 1))
      else $error("pvt job count beyond queue plus generator");
   assert property (@(posedge clock) disable iff (reset)
                    pvt_done |-> pvt_cnt_ff != 3'd0)
      else $error("pvt burst finished with no pvt job pending");
   assert property (@(posedge clock) disable iff (reset)
                    buf_wr.en |-> pvt_cnt_ff == 3'd0)
      else $error("payload buffer overwritten during field burst");

endmodule
`default_nettype wire
